// ===== sv/gpio_pin_control_registers_core_assert.svh =====
// Assertion macros shared by the GPIO pin control register block.
// They expect signals named clk and rst_n in the including scope.
`ifndef GPIO_PIN_CONTROL_REGISTERS_CORE_ASSERT_SVH
`define GPIO_PIN_CONTROL_REGISTERS_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GPC_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("gpc assertion failed");

// Next-cycle implication, checked out of reset.
`define GPC_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("gpc assertion failed");

`endif

// ===== sv/gpc_pkg.sv =====
// Types and constants for the GPIO pin control register block.
// No dependencies; every other file of the block but the assertion header imports it.
package gpc_pkg;

    localparam int DATA_W      = 32;
    localparam int PIN_FIELD_W = 30;
    localparam int BANK_W      = 2;
    localparam int OFFSET_W    = 8;
    localparam int WORD_W      = OFFSET_W - 2;
    localparam int PIN_IDX_W   = 5;
    localparam int FUNC_W      = 5;
    localparam int PAD_W       = 8;

    localparam logic [FUNC_W-1:0] FUNC_RESET = 5'h1F;
    // Input enable, pull-down.
    localparam logic [PAD_W-1:0]  PAD_RESET  = 8'h56;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [BANK_W-1:0] BANK_CTRL   = 2'd0;
    localparam logic [BANK_W-1:0] BANK_PAD    = 2'd1;
    localparam logic [BANK_W-1:0] BANK_SETCLR = 2'd2;

    localparam logic [OFFSET_W-1:0] SC_IN      = 8'h04;
    localparam logic [OFFSET_W-1:0] SC_OUT_SET = 8'h14;
    localparam logic [OFFSET_W-1:0] SC_OUT_CLR = 8'h18;
    localparam logic [OFFSET_W-1:0] SC_OE_SET  = 8'h24;
    localparam logic [OFFSET_W-1:0] SC_OE_CLR  = 8'h28;

    typedef enum logic [2:0] {
        TGT_FUNC,
        TGT_PAD,
        TGT_LEVELS,
        TGT_OUT_SET,
        TGT_OUT_CLR,
        TGT_OE_SET,
        TGT_OE_CLR,
        TGT_NONE
    } gpc_target_t;

    typedef struct packed {
        logic                 bad;
        gpc_target_t          target;
        logic [PIN_IDX_W-1:0] pin;
    } gpc_decode_t;

endpackage

// ===== sv/gpc_if.sv =====
// Request and response channel interfaces of the GPIO pin control block.
// Depends on gpc_pkg for field widths.
interface gpc_req_if
    import gpc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [BANK_W-1:0]      bank;
    logic [OFFSET_W-1:0]    offset;
    logic [DATA_W-1:0]      write_data;
    logic [PIN_FIELD_W-1:0] pin_levels;

    modport source (output valid, op, bank, offset, write_data, pin_levels, input ready);
    modport sink   (input valid, op, bank, offset, write_data, pin_levels, output ready);
endinterface

interface gpc_rsp_if
    import gpc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [DATA_W-1:0]      read_data;
    logic                   bad_address;
    logic [PIN_FIELD_W-1:0] pin_out;
    logic [PIN_FIELD_W-1:0] pin_oe;

    modport source (output valid, read_data, bad_address, pin_out, pin_oe, input ready);
    modport sink   (input valid, read_data, bad_address, pin_out, pin_oe, output ready);
endinterface

// ===== sv/gpc_decode.sv =====
// Address decode for one bus access: maps bank, offset and access kind
// to a register target and pin index. Depends on gpc_pkg.
module gpc_decode
    import gpc_pkg::*;
#(
    parameter int NUM_PINS = 30
)
(
    input  logic                op,
    input  logic [BANK_W-1:0]   bank,
    input  logic [OFFSET_W-1:0] offset,
    output gpc_decode_t         dec
);

    localparam logic [WORD_W-1:0] PIN_LIMIT = WORD_W'(NUM_PINS);

    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   pad_pin;
    logic [OFFSET_W-1:0] word_off;

    assign word     = offset[OFFSET_W-1:2];
    assign pad_pin  = word - WORD_W'(1);
    assign word_off = {word, 2'b00};

    always_comb
    begin
        dec = '{bad: 1'b1, target: TGT_NONE, pin: '0};
        unique case (bank)
            BANK_CTRL:
            begin
                // Function selects sit on every other word, starting at word one.
                if (word[0] && ({1'b0, word[WORD_W-1:1]} < PIN_LIMIT))
                begin
                    dec.bad    = 1'b0;
                    dec.target = TGT_FUNC;
                    dec.pin    = word[WORD_W-1:1];
                end
            end
            BANK_PAD:
            begin
                if ((word != '0) && (pad_pin < PIN_LIMIT))
                begin
                    dec.bad    = 1'b0;
                    dec.target = TGT_PAD;
                    dec.pin    = pad_pin[PIN_IDX_W-1:0];
                end
            end
            BANK_SETCLR:
            begin
                // The level register is read-only; the set and clear registers
                // are write-only.
                if (word_off == SC_IN)
                begin
                    if (op == OP_READ)
                    begin
                        dec.bad    = 1'b0;
                        dec.target = TGT_LEVELS;
                    end
                end
                else if (op == OP_WRITE)
                begin
                    if (word_off == SC_OUT_SET)
                    begin
                        dec.bad    = 1'b0;
                        dec.target = TGT_OUT_SET;
                    end
                    else if (word_off == SC_OUT_CLR)
                    begin
                        dec.bad    = 1'b0;
                        dec.target = TGT_OUT_CLR;
                    end
                    else if (word_off == SC_OE_SET)
                    begin
                        dec.bad    = 1'b0;
                        dec.target = TGT_OE_SET;
                    end
                    else if (word_off == SC_OE_CLR)
                    begin
                        dec.bad    = 1'b0;
                        dec.target = TGT_OE_CLR;
                    end
                end
            end
            default:
            begin
                dec = '{bad: 1'b1, target: TGT_NONE, pin: '0};
            end
        endcase
    end

endmodule

// ===== sv/gpio_pin_control_registers_core.sv =====
// Top level of the GPIO pin control register block.
// Depends on gpc_pkg, gpc_if (request and response channels), gpc_decode and the assertion header.
//
// The block takes one bus access per clock cycle and returns one response beat for each
// request beat, in order. A request is captured in an input register, decoded and applied
// to the register file when the input stage advances, and its response is held in an output
// register. The register file update sets the rate of one access per cycle, which holds
// as long as the response side keeps ready high; a stalled response holds the input stage
// as well. The pin_out and pin_oe fields of a response give the output levels and enables
// after that access. There is no clearing pass: the register file and the valid flags
// take their values at reset.
`include "gpio_pin_control_registers_core_assert.svh"

module gpio_pin_control_registers_core
    import gpc_pkg::*;
#(
    parameter int NUM_PINS = 30
)
(
    input  logic     clk,
    input  logic     rst_n,
    gpc_req_if.sink  req,
    gpc_rsp_if.source rsp
);

    localparam int PIN_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam logic [DATA_W-1:0] PIN_MASK = {DATA_W{1'b1}} >> (DATA_W - NUM_PINS);

    // Input stage.
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   s1_op_reg;
    logic [BANK_W-1:0]      s1_bank_reg;
    logic [OFFSET_W-1:0]    s1_offset_reg;
    logic [DATA_W-1:0]      s1_wdata_reg;
    logic [PIN_FIELD_W-1:0] s1_levels_reg;

    // Result stage.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [DATA_W-1:0]      read_data_reg;
    logic [DATA_W-1:0]      read_data_next;
    logic                   bad_address_reg;
    logic [PIN_FIELD_W-1:0] pin_out_reg;
    logic [PIN_FIELD_W-1:0] pin_oe_reg;

    // Register file.
    logic [FUNC_W-1:0]   func_sel_reg [NUM_PINS];
    logic [PAD_W-1:0]    pad_reg      [NUM_PINS];
    logic [NUM_PINS-1:0] out_level_reg;
    logic [NUM_PINS-1:0] out_level_next;
    logic [NUM_PINS-1:0] out_enable_reg;
    logic [NUM_PINS-1:0] out_enable_next;

    logic                req_fire;
    logic                s1_adv;
    gpc_decode_t         dec;
    logic [PIN_W-1:0]    pin_idx;
    logic [NUM_PINS-1:0] mask;
    logic                is_write;
    logic                wr_func;
    logic                wr_pad;
    logic [DATA_W-1:0]   rd_value;

    // Handshake: the input stage moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign s1_adv         = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready      = !s1_valid_reg || s1_adv;
    assign req_fire       = req.valid && req.ready;
    assign s1_valid_next  = req_fire || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg     <= req.op;
            s1_bank_reg   <= req.bank;
            s1_offset_reg <= req.offset;
            s1_wdata_reg  <= req.write_data;
            s1_levels_reg <= req.pin_levels;
        end
    end

    gpc_decode #(
        .NUM_PINS (NUM_PINS)
    ) u_decode (
        .op     (s1_op_reg),
        .bank   (s1_bank_reg),
        .offset (s1_offset_reg),
        .dec    (dec)
    );

    assign pin_idx  = dec.pin[PIN_W-1:0];
    assign mask     = s1_wdata_reg[NUM_PINS-1:0];
    assign is_write = (s1_op_reg == OP_WRITE);
    assign wr_func  = !dec.bad && is_write && (dec.target == TGT_FUNC);
    assign wr_pad   = !dec.bad && is_write && (dec.target == TGT_PAD);

    always_comb
    begin
        out_level_next  = out_level_reg;
        out_enable_next = out_enable_reg;
        rd_value        = '0;
        unique case (dec.target)
            TGT_FUNC:    rd_value = DATA_W'(func_sel_reg[pin_idx]);
            TGT_PAD:     rd_value = DATA_W'(pad_reg[pin_idx]);
            TGT_LEVELS:  rd_value = DATA_W'(s1_levels_reg) & PIN_MASK;
            TGT_OUT_SET: out_level_next  = out_level_reg | mask;
            TGT_OUT_CLR: out_level_next  = out_level_reg & ~mask;
            TGT_OE_SET:  out_enable_next = out_enable_reg | mask;
            TGT_OE_CLR:  out_enable_next = out_enable_reg & ~mask;
            TGT_NONE:    rd_value = '0;
        endcase
        read_data_next = (dec.bad || is_write) ? '0 : rd_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PINS; i++)
            begin
                func_sel_reg[i] <= FUNC_RESET;
                pad_reg[i]      <= PAD_RESET;
            end
            out_level_reg  <= '0;
            out_enable_reg <= '0;
        end
        else if (s1_adv)
        begin
            if (wr_func)
            begin
                func_sel_reg[pin_idx] <= s1_wdata_reg[FUNC_W-1:0];
            end
            if (wr_pad)
            begin
                pad_reg[pin_idx] <= s1_wdata_reg[PAD_W-1:0];
            end
            out_level_reg  <= out_level_next;
            out_enable_reg <= out_enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            read_data_reg   <= read_data_next;
            bad_address_reg <= dec.bad;
            pin_out_reg     <= PIN_FIELD_W'(out_level_next);
            pin_oe_reg      <= PIN_FIELD_W'(out_enable_next);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = read_data_reg;
    assign rsp.bad_address = bad_address_reg;
    assign rsp.pin_out     = pin_out_reg;
    assign rsp.pin_oe      = pin_oe_reg;

    `GPC_ASSERT_NOW(a_bad_reads_zero, rsp.valid && rsp.bad_address, rsp.read_data == '0)
    `GPC_ASSERT_NEXT(a_adv_gives_beat, s1_adv, rsp.valid)
    `GPC_ASSERT_NEXT(a_idle_keeps_pins, !s1_adv, $stable(out_level_reg) && $stable(out_enable_reg))
    `GPC_ASSERT_NOW(a_stall_blocks_input, out_valid_reg && !rsp.ready && s1_valid_reg, !req.ready)

endmodule

// ===== test/gpc_access_checker.sv =====
`timescale 1ns / 100ps
// Checker for the GPIO pin control register block: it predicts every response beat
// from the request beats it sees and compares them in order. Depends on gpc_pkg and gpc_if.
module gpc_access_checker
    import gpc_pkg::*;
#(
    parameter int NUM_PINS = 30
)
(
    input  logic clk,
    input  logic rst_n,
    gpc_req_if   req,
    gpc_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int REG_BASE    = 4;
    localparam int FUNC_STRIDE = 8;
    localparam int PAD_STRIDE  = 4;
    localparam logic [PIN_FIELD_W-1:0] PIN_MASK =
        (NUM_PINS >= PIN_FIELD_W) ? {PIN_FIELD_W{1'b1}}
                                  : PIN_FIELD_W'((64'd1 << NUM_PINS) - 1);

    typedef struct packed {
        logic [DATA_W-1:0]      read_data;
        logic                   bad_address;
        logic [PIN_FIELD_W-1:0] pin_out;
        logic [PIN_FIELD_W-1:0] pin_oe;
    } gpio_reply_t;

    logic [FUNC_W-1:0]      func_sel [NUM_PINS];
    logic [PAD_W-1:0]       pad_cfg  [NUM_PINS];
    logic [PIN_FIELD_W-1:0] out_level;
    logic [PIN_FIELD_W-1:0] out_enable;
    gpio_reply_t            pending_replies [$];

    function automatic void reset_registers();
        for (int i = 0; i < NUM_PINS; i++)
        begin
            func_sel[i] = FUNC_RESET;
            pad_cfg[i]  = PAD_RESET;
        end
        out_level  = '0;
        out_enable = '0;
    endfunction

    // Applies one access to the predicted register state and returns its reply.
    function automatic gpio_reply_t apply_access(
        input logic                   op,
        input logic [BANK_W-1:0]      bank,
        input logic [OFFSET_W-1:0]    offset,
        input logic [DATA_W-1:0]      wdata,
        input logic [PIN_FIELD_W-1:0] levels
    );
        gpio_reply_t            r;
        logic [OFFSET_W-1:0]    word_off;
        logic [PIN_FIELD_W-1:0] mask;
        int                     w;
        int                     pin;
        r        = '0;
        word_off = {offset[OFFSET_W-1:2], 2'b00};
        w        = int'(word_off);
        mask     = wdata[PIN_FIELD_W-1:0] & PIN_MASK;
        case (bank)
            BANK_CTRL:
            begin
                pin = (w - REG_BASE) / FUNC_STRIDE;
                if (w < REG_BASE || (w - REG_BASE) % FUNC_STRIDE != 0 || pin >= NUM_PINS)
                    r.bad_address = 1'b1;
                else if (op == OP_WRITE)
                    func_sel[pin] = wdata[FUNC_W-1:0];
                else
                    r.read_data = DATA_W'(func_sel[pin]);
            end
            BANK_PAD:
            begin
                pin = (w - REG_BASE) / PAD_STRIDE;
                if (w < REG_BASE || pin >= NUM_PINS)
                    r.bad_address = 1'b1;
                else if (op == OP_WRITE)
                    pad_cfg[pin] = wdata[PAD_W-1:0];
                else
                    r.read_data = DATA_W'(pad_cfg[pin]);
            end
            BANK_SETCLR:
            begin
                case (word_off)
                    SC_IN:
                    begin
                        // The input level register is read-only.
                        if (op == OP_WRITE)
                            r.bad_address = 1'b1;
                        else
                            r.read_data = DATA_W'(levels & PIN_MASK);
                    end
                    SC_OUT_SET, SC_OUT_CLR, SC_OE_SET, SC_OE_CLR:
                    begin
                        // The set and clear registers are write-only.
                        if (op == OP_READ)
                            r.bad_address = 1'b1;
                        else
                        begin
                            case (word_off)
                                SC_OUT_SET: out_level  = out_level | mask;
                                SC_OUT_CLR: out_level  = out_level & ~mask;
                                SC_OE_SET:  out_enable = out_enable | mask;
                                default:    out_enable = out_enable & ~mask;
                            endcase
                        end
                    end
                    default: r.bad_address = 1'b1;
                endcase
            end
            default: r.bad_address = 1'b1;
        endcase
        if (r.bad_address)
            r.read_data = '0;
        r.pin_out = out_level;
        r.pin_oe  = out_enable;
        return r;
    endfunction

    task automatic report_field(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gpio_reply_t want;
        if (!rst_n)
        begin
            reset_registers();
            pending_replies.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                pending_replies.push_back(apply_access(req.op, req.bank, req.offset,
                                                       req.write_data, req.pin_levels));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: response beat with no request waiting, read_data %h",
                             $time, rsp.read_data);
                    mismatches++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (rsp.read_data !== want.read_data)
                        report_field("read_data", want.read_data, rsp.read_data);
                    if (rsp.bad_address !== want.bad_address)
                        report_field("bad_address", DATA_W'(want.bad_address),
                                     DATA_W'(rsp.bad_address));
                    if (rsp.pin_out !== want.pin_out)
                        report_field("pin_out", DATA_W'(want.pin_out), DATA_W'(rsp.pin_out));
                    if (rsp.pin_oe !== want.pin_oe)
                        report_field("pin_oe", DATA_W'(want.pin_oe), DATA_W'(rsp.pin_oe));
                end
            end
            outstanding = pending_replies.size();
        end
    end

endmodule

// ===== test/gpio_pin_control_registers_core_tb.sv =====
`timescale 1ns / 100ps
// Top of the GPIO pin control register testbench: clock, reset, request and response
// traffic and the verdict. Depends on gpc_pkg, gpc_if, gpc_access_checker and the block.
module gpio_pin_control_registers_core_tb;
    import gpc_pkg::*;

    localparam int NUM_PINS           = 30;
    localparam int REG_BASE           = 4;
    localparam int FUNC_STRIDE        = 8;
    localparam int PAD_STRIDE         = 4;
    localparam int PHASE_BEATS        = 270;
    localparam int BURST_BEATS        = 40;
    localparam int HOLDOFF_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int DRAIN_CYCLES       = 8;
    localparam int SENDER_IDLE_PCT    = 62;
    localparam int RECEIVER_STALL_PCT = 62;
    localparam int BOTH_IDLE_PCT      = 33;
    localparam logic [BANK_W-1:0] BANK_UNMAPPED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic       clk;
    logic       rst_n;
    idle_mode_t mode = IDLE_NONE;
    bit         holdoff_start = 1'b0;
    int         holdoff_left = 0;
    int         quiet_cycles = 0;
    int         mismatches;
    int         outstanding;

    gpc_req_if req ();
    gpc_rsp_if rsp ();

    gpio_pin_control_registers_core #(
        .NUM_PINS (NUM_PINS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    gpc_access_checker #(
        .NUM_PINS (NUM_PINS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int sender_idle_pct();
        case (mode)
            IDLE_SENDER: return SENDER_IDLE_PCT;
            IDLE_BOTH:   return BOTH_IDLE_PCT;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (mode)
            IDLE_RECEIVER: return RECEIVER_STALL_PCT;
            IDLE_BOTH:     return BOTH_IDLE_PCT;
            default:       return 0;
        endcase
    endfunction

    function automatic logic [OFFSET_W-1:0] func_offset(input int pin);
        return OFFSET_W'(REG_BASE + pin * FUNC_STRIDE);
    endfunction

    function automatic logic [OFFSET_W-1:0] pad_offset(input int pin);
        return OFFSET_W'(REG_BASE + pin * PAD_STRIDE);
    endfunction

    // The response side stalls at random, or holds off for a long stretch on request.
    always @(negedge clk)
    begin
        if (holdoff_start)
        begin
            holdoff_left  = HOLDOFF_CYCLES;
            holdoff_start = 1'b0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("gpio_pin_control_registers_core_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Entered and left at a falling edge; valid stays high after the beat is taken.
    task automatic send_access(
        input logic                   op,
        input logic [BANK_W-1:0]      bank,
        input logic [OFFSET_W-1:0]    offset,
        input logic [DATA_W-1:0]      wdata,
        input logic [PIN_FIELD_W-1:0] levels
    );
        while ($urandom_range(99) < sender_idle_pct())
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.op         <= op;
        req.bank       <= bank;
        req.offset     <= offset;
        req.write_data <= wdata;
        req.pin_levels <= levels;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly mapped registers with random content, the rest any offset in any bank.
    task automatic send_random_access();
        logic                op;
        logic [BANK_W-1:0]   bank;
        logic [OFFSET_W-1:0] offset;
        logic [DATA_W-1:0]   wdata;
        int                  pick;
        op   = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 35)
            bank = BANK_CTRL;
        else if (pick < 65)
            bank = BANK_PAD;
        else if (pick < 95)
            bank = BANK_SETCLR;
        else
            bank = BANK_UNMAPPED;
        if ($urandom_range(99) < 85)
        begin
            case (bank)
                BANK_CTRL: offset = func_offset($urandom_range(NUM_PINS - 1));
                BANK_PAD:  offset = pad_offset($urandom_range(NUM_PINS - 1));
                default:
                begin
                    case ($urandom_range(4))
                        0:       offset = SC_IN;
                        1:       offset = SC_OUT_SET;
                        2:       offset = SC_OUT_CLR;
                        3:       offset = SC_OE_SET;
                        default: offset = SC_OE_CLR;
                    endcase
                end
            endcase
            offset[1:0] = 2'($urandom_range(3));
        end
        else
            offset = OFFSET_W'($urandom_range(255));
        pick = $urandom_range(9);
        if (pick == 0)
            wdata = '0;
        else if (pick == 1)
            wdata = '1;
        else
            wdata = $urandom();
        send_access(op, bank, offset, wdata, PIN_FIELD_W'($urandom()));
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.op         = OP_READ;
        req.bank       = BANK_CTRL;
        req.offset     = '0;
        req.write_data = '0;
        req.pin_levels = '0;
        rsp.ready      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values, stored widths, decode edges and every bad access kind.
        send_access(OP_READ,  BANK_CTRL, func_offset(0), '0, '0);
        send_access(OP_READ,  BANK_CTRL, func_offset(NUM_PINS - 1), '1, '1);
        send_access(OP_READ,  BANK_PAD, pad_offset(0), '0, '1);
        send_access(OP_READ,  BANK_PAD, pad_offset(NUM_PINS - 1), '1, '0);
        send_access(OP_WRITE, BANK_CTRL, func_offset(0), '1, '0);
        send_access(OP_READ,  BANK_CTRL, func_offset(0) | 8'h03, '0, '0);
        send_access(OP_WRITE, BANK_PAD, pad_offset(NUM_PINS - 1), 32'hFFFF_FF3C, '1);
        send_access(OP_READ,  BANK_PAD, pad_offset(NUM_PINS - 1) | 8'h02, '0, '0);
        send_access(OP_READ,  BANK_CTRL, 8'h00, '0, '0);
        send_access(OP_WRITE, BANK_CTRL, 8'h08, '1, '0);
        send_access(OP_READ,  BANK_CTRL, func_offset(NUM_PINS), '0, '0);
        send_access(OP_READ,  BANK_PAD, pad_offset(NUM_PINS), '0, '0);
        send_access(OP_WRITE, BANK_PAD, 8'hFF, '1, '1);
        send_access(OP_READ,  BANK_PAD, 8'h00, '0, '0);
        send_access(OP_READ,  BANK_SETCLR, SC_IN, '1, '1);
        send_access(OP_READ,  BANK_SETCLR, SC_IN | 8'h03, '0, 30'h2AAA_AAAA);
        send_access(OP_WRITE, BANK_SETCLR, SC_IN, '1, '1);
        send_access(OP_WRITE, BANK_SETCLR, SC_OUT_SET, '1, '0);
        send_access(OP_WRITE, BANK_SETCLR, SC_OUT_CLR, 32'h5555_5555, '0);
        send_access(OP_WRITE, BANK_SETCLR, SC_OE_SET, '1, '0);
        send_access(OP_WRITE, BANK_SETCLR, SC_OE_CLR, 32'hAAAA_AAAA, '0);
        send_access(OP_READ,  BANK_SETCLR, SC_OE_SET, '0, '0);
        send_access(OP_READ,  BANK_SETCLR, 8'h10, '0, '0);
        send_access(OP_READ,  BANK_UNMAPPED, func_offset(0), '0, '0);
        send_access(OP_WRITE, BANK_UNMAPPED, 8'hFF, '1, '1);

        for (int phase = 0; phase < 4; phase++)
        begin
            mode = idle_mode_t'(phase);
            repeat (PHASE_BEATS)
                send_random_access();
            if (phase == 1)
            begin
                // The response side holds off while request beats keep coming.
                mode = IDLE_NONE;
                req.valid <= 1'b0;
                @(posedge clk);
                holdoff_start = 1'b1;
                @(negedge clk);
                repeat (BURST_BEATS)
                    send_random_access();
            end
            else if (phase == 2)
            begin
                req.valid <= 1'b0;
                wait (outstanding == 0);
                @(negedge clk);
            end
        end

        req.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("gpio_pin_control_registers_core_tb: PASS");
        else
            $display("gpio_pin_control_registers_core_tb: FAIL");
        $finish;
    end

endmodule
